// ===== rtl/core/cvsd_pkg.sv =====
// Shared types, constants and control structure of the CVSD codec core.
// No dependencies; used by every module of the core.
`timescale 1ns / 1ps
`default_nettype none

package cvsd_pkg;

  // Algorithm constants
  localparam int unsigned RUN_LENGTH = 4;
  localparam int unsigned FRAC_BITS  = 15;
  localparam int unsigned FULL_SCALE = 32767;
  localparam logic        BIT_ONE    = 1'b1;

  // Field and state widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned INTEG_W  = 32;
  localparam int unsigned RATE_W   = 15;
  localparam int unsigned SLOPE_W  = 8;
  localparam int unsigned CFG_W    = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TDATA_W  = 24;

  // Shared multiplier widths: A is signed and wide, B is a zero-extended rate
  localparam int unsigned MUL_A_W = INTEG_W + 2;
  localparam int unsigned MUL_B_W = RATE_W + 1;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYL_RISE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYL_DECAY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INT_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INT_DECAY  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_FLOOR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_GAIN = 3'd6;

  // Configuration reset values
  localparam logic                RST_MODE       = 1'b0;
  localparam logic [RATE_W-1:0]   RST_SYL_RISE   = 15'd1024;
  localparam logic [RATE_W-1:0]   RST_SYL_DECAY  = 15'd64;
  localparam logic [RATE_W-1:0]   RST_INT_GAIN   = 15'd4096;
  localparam logic [RATE_W-1:0]   RST_INT_DECAY  = 15'd32;
  localparam logic [RATE_W-1:0]   RST_STEP_FLOOR = 15'd64;
  localparam logic [SLOPE_W-1:0]  RST_SLOPE_GAIN = 8'd1;

  // Codec modes
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_STEP,
    ST_UPD_STEP,
    ST_MUL_TGT,
    ST_UPD_TGT,
    ST_MUL_GAIN,
    ST_UPD_GAIN,
    ST_MUL_DECAY,
    ST_UPD_DECAY,
    ST_OUT
  } cvsd_state_e;

  typedef enum logic [1:0] {
    OP_STEP,
    OP_TGT,
    OP_GAIN,
    OP_DECAY
  } cvsd_opsel_e;

  typedef struct packed {
    logic        in_ready;
    logic        mul_en;
    cvsd_opsel_e op_sel;
    logic        upd_step;
    logic        upd_tgt;
    logic        upd_gain;
    logic        upd_decay;
    logic        out_load;
  } cvsd_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/cvsd_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on cvsd_pkg for operand widths.
`timescale 1ns / 1ps
`default_nettype none

module cvsd_mul (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic signed [cvsd_pkg::MUL_A_W-1:0] a_i,
  input  wire logic signed [cvsd_pkg::MUL_B_W-1:0] b_i,
  output logic signed [cvsd_pkg::PROD_W-1:0]       prod_o
);

  logic signed [cvsd_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= cvsd_pkg::PROD_W'(a_i) * cvsd_pkg::PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== rtl/core/cvsd_ctrl.sv =====
// Sequencer of the CVSD core: steps one item through four multiply/update pairs.
// Depends on cvsd_pkg for the state enum and control structure.
`timescale 1ns / 1ps
`default_nettype none

module cvsd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              out_free_i,
  output cvsd_pkg::cvsd_ctrl_t   ctrl_o
);

  cvsd_pkg::cvsd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cvsd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    ctrl_o           = '0;
    ctrl_o.op_sel    = cvsd_pkg::OP_STEP;
    case (state_q)
      cvsd_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          state_d = cvsd_pkg::ST_MUL_STEP;
        end
      end
      cvsd_pkg::ST_MUL_STEP: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = cvsd_pkg::OP_STEP;
        state_d       = cvsd_pkg::ST_UPD_STEP;
      end
      cvsd_pkg::ST_UPD_STEP: begin
        ctrl_o.upd_step = 1'b1;
        state_d         = cvsd_pkg::ST_MUL_TGT;
      end
      cvsd_pkg::ST_MUL_TGT: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = cvsd_pkg::OP_TGT;
        state_d       = cvsd_pkg::ST_UPD_TGT;
      end
      cvsd_pkg::ST_UPD_TGT: begin
        ctrl_o.upd_tgt = 1'b1;
        state_d        = cvsd_pkg::ST_MUL_GAIN;
      end
      cvsd_pkg::ST_MUL_GAIN: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = cvsd_pkg::OP_GAIN;
        state_d       = cvsd_pkg::ST_UPD_GAIN;
      end
      cvsd_pkg::ST_UPD_GAIN: begin
        ctrl_o.upd_gain = 1'b1;
        state_d         = cvsd_pkg::ST_MUL_DECAY;
      end
      cvsd_pkg::ST_MUL_DECAY: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.op_sel = cvsd_pkg::OP_DECAY;
        state_d       = cvsd_pkg::ST_UPD_DECAY;
      end
      cvsd_pkg::ST_UPD_DECAY: begin
        ctrl_o.upd_decay = 1'b1;
        state_d          = cvsd_pkg::ST_OUT;
      end
      cvsd_pkg::ST_OUT: begin
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = cvsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = cvsd_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/cvsd_codec_core.sv =====
// CVSD codec core: one item at a time, from input transfer to result valid.
// An item passes through four dependent fixed-point multiplies sharing one registered
// multiplier, each followed by an update step, and then waits for the output register
// to be free. A new input is taken while a result waits in the output register.
// Reset (rst_ni low, asynchronous) restores the config defaults, clears the run history
// and integrator, and loads the step level with the default step floor.
`timescale 1ns / 1ps
`default_nettype none

module cvsd_codec_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Input stream. tdata: [15:0] sample_in (signed), [16] bit_in, [23:17] zero.
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  input  wire logic [cvsd_pkg::TDATA_W-1:0]       s_axis_tdata,
  // Result stream. tdata: [0] bit_out, [16:1] sample_out (signed), [23:17] zero.
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  output logic [cvsd_pkg::TDATA_W-1:0]            m_axis_tdata,
  // Configuration write port
  input  wire logic                               cfg_we_i,
  input  wire logic [cvsd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [cvsd_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int unsigned SW  = cvsd_pkg::STEP_W;
  localparam int unsigned IW  = cvsd_pkg::INTEG_W;
  localparam int unsigned AW  = cvsd_pkg::MUL_A_W;
  localparam int unsigned BW  = cvsd_pkg::MUL_B_W;
  localparam int unsigned PW  = cvsd_pkg::PROD_W;
  localparam int unsigned RL  = cvsd_pkg::RUN_LENGTH;
  // Step update works in a signed word that holds the step plus a scaled delta.
  localparam int unsigned SSW = SW + 4;
  // Integrator updates work in a signed word with headroom above 32 bits.
  localparam int unsigned ISW = IW + 3;
  // Width of the integer target magnitude, step times slope gain.
  localparam int unsigned TGW = SW + cvsd_pkg::SLOPE_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user writes them only with the core idle; unenforced.
  // ---------------------------------------------------------------------------
  logic                              mode_q;
  logic [cvsd_pkg::RATE_W-1:0]       syl_rise_q;
  logic [cvsd_pkg::RATE_W-1:0]       syl_decay_q;
  logic [cvsd_pkg::RATE_W-1:0]       int_gain_q;
  logic [cvsd_pkg::RATE_W-1:0]       int_decay_q;
  logic [cvsd_pkg::RATE_W-1:0]       step_floor_q;
  logic [cvsd_pkg::SLOPE_W-1:0]      slope_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= cvsd_pkg::RST_MODE;
      syl_rise_q   <= cvsd_pkg::RST_SYL_RISE;
      syl_decay_q  <= cvsd_pkg::RST_SYL_DECAY;
      int_gain_q   <= cvsd_pkg::RST_INT_GAIN;
      int_decay_q  <= cvsd_pkg::RST_INT_DECAY;
      step_floor_q <= cvsd_pkg::RST_STEP_FLOOR;
      slope_gain_q <= cvsd_pkg::RST_SLOPE_GAIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cvsd_pkg::REG_MODE:       mode_q       <= cfg_wdata_i[0];
        cvsd_pkg::REG_SYL_RISE:   syl_rise_q   <= cfg_wdata_i;
        cvsd_pkg::REG_SYL_DECAY:  syl_decay_q  <= cfg_wdata_i;
        cvsd_pkg::REG_INT_GAIN:   int_gain_q   <= cfg_wdata_i;
        cvsd_pkg::REG_INT_DECAY:  int_decay_q  <= cfg_wdata_i;
        cvsd_pkg::REG_STEP_FLOOR: step_floor_q <= cfg_wdata_i;
        cvsd_pkg::REG_SLOPE_GAIN: slope_gain_q <= cfg_wdata_i[cvsd_pkg::SLOPE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and shared multiplier
  // ---------------------------------------------------------------------------
  cvsd_pkg::cvsd_ctrl_t ctrl;
  logic                 out_free;
  logic                 in_fire;
  logic                 m_valid_q;

  assign out_free = !m_valid_q || m_axis_tready;

  cvsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign s_axis_tready = ctrl.in_ready;
  assign in_fire       = s_axis_tvalid && ctrl.in_ready;

  logic signed [AW-1:0] mul_a;
  logic signed [BW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  cvsd_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl.mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // ---------------------------------------------------------------------------
  // Algorithm state
  // ---------------------------------------------------------------------------
  logic [RL-1:0]        run_q;
  logic [SW-1:0]        step_q;
  logic signed [IW-1:0] integ_q;
  logic                 bit_q;
  logic signed [AW-1:0] diff_q;

  // Comparator bit in encode mode; the received bit in decode mode.
  logic signed [IW-1:0] sample_ext;
  logic                 bit_new;
  logic                 is_run;

  assign sample_ext = IW'(signed'(s_axis_tdata[cvsd_pkg::SAMPLE_W-1:0]));
  assign bit_new    = (mode_q == cvsd_pkg::MODE_ENCODE) ? (sample_ext > integ_q)
                                                        : s_axis_tdata[cvsd_pkg::SAMPLE_W];
  // A run of equal bits in the history raises the step level.
  assign is_run     = (run_q == '0) || (run_q == '1);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.op_sel)
      cvsd_pkg::OP_STEP: begin
        if (is_run) begin
          mul_a = AW'(cvsd_pkg::FULL_SCALE) - AW'(step_q);
          mul_b = BW'(syl_rise_q);
        end else begin
          mul_a = AW'(step_q) - AW'(step_floor_q);
          mul_b = BW'(syl_decay_q);
        end
      end
      cvsd_pkg::OP_TGT: begin
        mul_a = AW'(step_q);
        mul_b = BW'(slope_gain_q);
      end
      cvsd_pkg::OP_GAIN: begin
        mul_a = diff_q;
        mul_b = BW'(int_gain_q);
      end
      cvsd_pkg::OP_DECAY: begin
        mul_a = AW'(integ_q);
        mul_b = BW'(int_decay_q);
      end
      default: ;
    endcase
  end

  // Floor-scaled product; the multiplier output is already signed.
  logic signed [PW-1:0]  prod_sh;
  logic signed [SSW-1:0] step_sum;
  logic [SW-1:0]         step_sat;
  logic [TGW-1:0]        tgt_mag;
  logic signed [AW-1:0]  tgt_signed;
  logic signed [ISW-1:0] gain_sum;
  logic signed [ISW-1:0] decay_sum;
  logic signed [IW-1:0]  gain_sat;
  logic signed [IW-1:0]  decay_sat;

  assign prod_sh = prod >>> cvsd_pkg::FRAC_BITS;

  // Step level: a run adds the scaled rise, otherwise the scaled decay is taken
  // off; the result is then held within 0..65535.
  assign step_sum = is_run ? SSW'(step_q) + prod_sh[SSW-1:0]
                           : SSW'(step_q) - prod_sh[SSW-1:0];
  always_comb begin
    if (step_sum < 0) begin
      step_sat = '0;
    end else if (step_sum > signed'(SSW'({SW{1'b1}}))) begin
      step_sat = '1;
    end else begin
      step_sat = step_sum[SW-1:0];
    end
  end

  // Target is plus or minus step times slope; its difference to the integrator
  // feeds the gain multiply.
  assign tgt_mag    = prod[TGW-1:0];
  assign tgt_signed = bit_q ? AW'(tgt_mag) : -AW'(tgt_mag);

  function automatic logic signed [IW-1:0] sat_integ(input logic signed [ISW-1:0] x);
    logic signed [ISW-1:0] hi;
    logic signed [ISW-1:0] lo;
    hi = ISW'({1'b0, {(IW-1){1'b1}}});
    lo = -hi - ISW'(1);
    if (x > hi) begin
      sat_integ = hi[IW-1:0];
    end else if (x < lo) begin
      sat_integ = lo[IW-1:0];
    end else begin
      sat_integ = x[IW-1:0];
    end
  endfunction

  assign gain_sum  = ISW'(integ_q) + prod_sh[ISW-1:0];
  assign decay_sum = ISW'(integ_q) - prod_sh[ISW-1:0];
  assign gain_sat  = sat_integ(gain_sum);
  assign decay_sat = sat_integ(decay_sum);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      step_q  <= SW'(cvsd_pkg::RST_STEP_FLOOR);
      integ_q <= '0;
    end else begin
      if (in_fire) begin
        run_q <= {run_q[RL-2:0], bit_new};
      end
      if (ctrl.upd_step) begin
        step_q <= step_sat;
      end
      if (ctrl.upd_gain) begin
        integ_q <= gain_sat;
      end else if (ctrl.upd_decay) begin
        integ_q <= decay_sat;
      end
    end
  end

  // Per-item working registers; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bit_q <= bit_new;
    end
    if (ctrl.upd_tgt) begin
      diff_q <= tgt_signed - AW'(integ_q);
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: the clamped integrator and the bit used this item.
  // ---------------------------------------------------------------------------
  logic signed [cvsd_pkg::SAMPLE_W-1:0] clamp_val;
  logic signed [cvsd_pkg::SAMPLE_W-1:0] m_sample_q;
  logic                                 m_bit_q;

  always_comb begin
    if (integ_q > IW'(32'sd32767)) begin
      clamp_val = 16'sh7FFF;
    end else if (integ_q < -IW'(32'sd32768)) begin
      clamp_val = 16'sh8000;
    end else begin
      clamp_val = integ_q[cvsd_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctrl.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      m_sample_q <= clamp_val;
      m_bit_q    <= bit_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(cvsd_pkg::TDATA_W - cvsd_pkg::SAMPLE_W - 1){1'b0}},
                          m_sample_q, m_bit_q};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The core works on one item at a time: no second transfer right after one.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // A result never overwrites one that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> (!m_valid_q || m_axis_tready))
    else $error("result register overwritten");

  // At most one update strobe is active at a time.
  a_one_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.upd_step, ctrl.upd_tgt, ctrl.upd_gain, ctrl.upd_decay, ctrl.out_load}))
    else $error("conflicting update strobes");

  // A multiply never coincides with an input transfer or a result load.
  a_mul_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.mul_en |-> !ctrl.in_ready && !ctrl.out_load)
    else $error("multiplier used outside the item sequence");

endmodule

`default_nettype wire

// ===== test/tb_cvsd_codec_core.sv =====
// Self-checking testbench for cvsd_codec_core: a directed table, then random phases,
// checked against a cycle-free model of the codec kept inside the bench.
// Depends on cvsd_pkg and cvsd_codec_core only.
`timescale 1ns / 1ps

module tb_cvsd_codec_core;

  localparam int     CYCLE_LIMIT = 500_000;
  localparam int     DRAIN_CYCLES = 30;
  localparam int     PHASES = 12;
  localparam int     PHASE_ITEMS = 125;
  localparam longint FULL_LVL = cvsd_pkg::FULL_SCALE;
  localparam longint I32_MAX = 64'sd2147483647;
  localparam longint I32_MIN = -I32_MAX - 1;
  // Index past the last register; writes to it must change nothing.
  localparam logic [cvsd_pkg::CFG_IDX_W-1:0] REG_NONE = 3'd7;

  typedef struct {
    logic               bit_v;
    logic signed [15:0] smp;
  } codec_word_t;

  typedef struct {
    logic                           is_cfg;
    logic [cvsd_pkg::CFG_IDX_W-1:0] idx;
    logic [cvsd_pkg::CFG_W-1:0]     wdata;
    logic signed [15:0]             smp;
    logic                           bin;
    logic                           typed;
    logic                           ebit;
    logic signed [15:0]             esmp;
  } plan_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [cvsd_pkg::TDATA_W-1:0]   s_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready;
  logic [cvsd_pkg::TDATA_W-1:0]   m_axis_tdata;
  logic                           cfg_we_i;
  logic [cvsd_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [cvsd_pkg::CFG_W-1:0]     cfg_wdata_i;

  cvsd_codec_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  // Mirror of the codec settings and state.
  logic                            mode_q;
  int                              rise_q, sdecay_q, igain_q, idecay_q, floor_q, slope_q;
  logic [cvsd_pkg::RUN_LENGTH-1:0] runs_q;
  longint                          step_q, integ_q;

  codec_word_t cvsd_words_q[$];
  plan_row_t   plan[$];
  int          errors = 0;
  int          cycles = 0;
  int          results = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> cvsd_pkg::FRAC_BITS;
  endfunction

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // One codec step: pick the delta bit, adapt the step level, move and leak the
  // integrator, and give out the bit and the clamped reconstruction.
  function automatic codec_word_t cvsd_track(input logic signed [15:0] smp, input logic bin);
    codec_word_t w;
    logic        b;
    longint      tgt;
    if (mode_q == cvsd_pkg::MODE_ENCODE) b = (longint'(smp) > integ_q);
    else b = bin;
    runs_q = {runs_q[cvsd_pkg::RUN_LENGTH-2:0], b};
    if (runs_q == '0 || runs_q == '1) step_q = step_q + fx_mul(FULL_LVL - step_q, rise_q);
    else step_q = step_q - fx_mul(step_q - floor_q, sdecay_q);
    step_q = clip(step_q, 0, 65535);
    tgt = (b ? step_q : -step_q) * slope_q;
    integ_q = clip(integ_q + fx_mul(tgt - integ_q, igain_q), I32_MIN, I32_MAX);
    integ_q = clip(integ_q - fx_mul(integ_q, idecay_q), I32_MIN, I32_MAX);
    w.bit_v = b;
    w.smp   = 16'(clip(integ_q, -32768, 32767));
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic report(input string what);
    $display("[%0t] MISMATCH %s", $time, what);
    errors++;
  endtask

  // Registers change only with the codec idle: input lowered and every result back.
  task automatic write_reg(input logic [cvsd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cvsd_pkg::CFG_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (cvsd_words_q.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      cvsd_pkg::REG_MODE:       mode_q   = val[0];
      cvsd_pkg::REG_SYL_RISE:   rise_q   = val;
      cvsd_pkg::REG_SYL_DECAY:  sdecay_q = val;
      cvsd_pkg::REG_INT_GAIN:   igain_q  = val;
      cvsd_pkg::REG_INT_DECAY:  idecay_q = val;
      cvsd_pkg::REG_STEP_FLOOR: floor_q  = val;
      cvsd_pkg::REG_SLOPE_GAIN: slope_q  = val[cvsd_pkg::SLOPE_W-1:0];
      default: ;
    endcase
  endtask

  // Offer one input transfer; valid stays high afterwards unless the next call idles.
  task automatic send_item(input logic signed [15:0] smp, input logic bin,
                           input logic typed, input codec_word_t known);
    int          gap;
    codec_word_t w;
    gap = pick_gap();
    cfg_we_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, bin, smp};
    do @(posedge clk_i); while (!s_axis_tready);
    w = cvsd_track(smp, bin);
    cvsd_words_q.push_back(typed ? known : w);
  endtask

  function automatic plan_row_t cfg_row(input logic [cvsd_pkg::CFG_IDX_W-1:0] idx,
                                        input logic [cvsd_pkg::CFG_W-1:0] val);
    plan_row_t r;
    r = '{1'b1, idx, val, 16'sd0, 1'b0, 1'b0, 1'b0, 16'sd0};
    return r;
  endfunction

  function automatic plan_row_t item_row(input logic signed [15:0] smp, input logic bin);
    plan_row_t r;
    r = '{1'b0, REG_NONE, 15'd0, smp, bin, 1'b0, 1'b0, 16'sd0};
    return r;
  endfunction

  function automatic plan_row_t known_row(input logic signed [15:0] smp, input logic bin,
                                          input logic ebit, input logic signed [15:0] esmp);
    plan_row_t r;
    r = '{1'b0, REG_NONE, 15'd0, smp, bin, 1'b1, ebit, esmp};
    return r;
  endfunction

  // Settings for a random phase: phase 2 puts every register but the mode at its top,
  // phase 3 at zero, the others mix zeros, maxima, small rates and raw 15-bit values.
  function automatic logic [cvsd_pkg::CFG_W-1:0] cfg_pick(
      input int p, input logic [cvsd_pkg::CFG_IDX_W-1:0] idx);
    int r;
    if (idx == cvsd_pkg::REG_MODE) return cvsd_pkg::CFG_W'($urandom_range(0, 32767));
    if (p == 2) return 15'h7FFF;
    if (p == 3) return 15'd0;
    r = $urandom_range(0, 9);
    if (r == 0) return 15'd0;
    if (r == 1) return 15'h7FFF;
    if (idx == cvsd_pkg::REG_SLOPE_GAIN && r < 6)
      return cvsd_pkg::CFG_W'($urandom_range(0, 16));
    if (r < 5) return cvsd_pkg::CFG_W'($urandom_range(0, 32767));
    return cvsd_pkg::CFG_W'($urandom_range(0, 2048));
  endfunction

  // Result side: random stalls of mostly short and a few long stretches.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 15) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(7, 39);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Every result transfer is held against the oldest expectation.
  always @(posedge clk_i) begin
    codec_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (cvsd_words_q.size() == 0) begin
        report($sformatf("result %0d arrived with nothing expected", results));
      end else begin
        want = cvsd_words_q.pop_front();
        if (m_axis_tdata[0] !== want.bit_v)
          report($sformatf("result %0d bit_out got %0b want %0b", results,
                           m_axis_tdata[0], want.bit_v));
        if ($signed(m_axis_tdata[16:1]) !== want.smp)
          report($sformatf("result %0d sample_out got %0d want %0d", results,
                           $signed(m_axis_tdata[16:1]), want.smp));
      end
      results++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d results outstanding", $time, cvsd_words_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    codec_word_t        none;
    plan_row_t          r;
    int                 walk;
    int                 run_left;
    logic               run_bit;
    logic signed [15:0] smp;
    logic               bin;

    none          = '{1'b0, 16'sd0};
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;

    mode_q   = cvsd_pkg::RST_MODE;
    rise_q   = cvsd_pkg::RST_SYL_RISE;
    sdecay_q = cvsd_pkg::RST_SYL_DECAY;
    igain_q  = cvsd_pkg::RST_INT_GAIN;
    idecay_q = cvsd_pkg::RST_INT_DECAY;
    floor_q  = cvsd_pkg::RST_STEP_FLOOR;
    slope_q  = cvsd_pkg::RST_SLOPE_GAIN;
    runs_q   = '0;
    step_q   = cvsd_pkg::RST_STEP_FLOOR;
    integ_q  = 0;

    // With the integrator gain at zero the integrator stays at zero, so the
    // comparator reduces to sample > 0 and every reconstruction is zero.
    plan.push_back(cfg_row(cvsd_pkg::REG_INT_GAIN, 15'd0));
    plan.push_back(known_row(16'sh7FFF, 1'b0, 1'b1, 16'sd0));
    plan.push_back(known_row(-16'sh8000, 1'b1, 1'b0, 16'sd0));
    plan.push_back(known_row(16'sd0, 1'b1, 1'b0, 16'sd0));
    plan.push_back(known_row(16'sd1, 1'b0, 1'b1, 16'sd0));
    plan.push_back(known_row(-16'sd1, 1'b1, 1'b0, 16'sd0));
    // Mode write with all bits set is masked to decode; the sample is ignored.
    plan.push_back(cfg_row(cvsd_pkg::REG_MODE, 15'h7FFF));
    plan.push_back(known_row(16'sh7FFF, 1'b1, 1'b1, 16'sd0));
    plan.push_back(known_row(-16'sh8000, 1'b0, 1'b0, 16'sd0));
    plan.push_back(cfg_row(REG_NONE, 15'h7FFF));
    // Floor far above the level: the decay rule drives the level upward.
    plan.push_back(cfg_row(cvsd_pkg::REG_STEP_FLOOR, 15'h7FFF));
    plan.push_back(cfg_row(cvsd_pkg::REG_SYL_DECAY, 15'h7FFF));
    plan.push_back(cfg_row(cvsd_pkg::REG_INT_GAIN, 15'h7FFF));
    plan.push_back(cfg_row(cvsd_pkg::REG_SLOPE_GAIN, 15'h7FFF));
    plan.push_back(item_row(16'sd0, 1'b1));
    plan.push_back(item_row(16'sd0, 1'b0));
    plan.push_back(item_row(16'sd0, 1'b1));
    plan.push_back(item_row(16'sd0, 1'b0));
    // Full rise and slope drive the reconstruction into both clamps.
    plan.push_back(cfg_row(cvsd_pkg::REG_STEP_FLOOR, 15'd0));
    plan.push_back(cfg_row(cvsd_pkg::REG_SYL_RISE, 15'h7FFF));
    plan.push_back(cfg_row(cvsd_pkg::REG_INT_DECAY, 15'd0));
    for (int i = 0; i < 5; i++) plan.push_back(item_row(16'sd0, 1'b1));
    for (int i = 0; i < 4; i++) plan.push_back(item_row(-16'sd1, 1'b0));
    plan.push_back(cfg_row(cvsd_pkg::REG_INT_DECAY, 15'h7FFF));
    plan.push_back(cfg_row(cvsd_pkg::REG_MODE, 15'd0));
    plan.push_back(item_row(16'sh7FFF, 1'b0));
    plan.push_back(item_row(-16'sh8000, 1'b1));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_cfg) write_reg(r.idx, r.wdata);
      else send_item(r.smp, r.bin, r.typed, '{r.ebit, r.esmp});
    end

    walk = 0;
    for (int p = 0; p < PHASES; p++) begin
      no_idle = (p % 4 == 1);
      for (int k = 0; k < 7; k++) begin
        if (p < 4 || $urandom_range(0, 1) == 1)
          write_reg(cvsd_pkg::CFG_IDX_W'(k), cfg_pick(p, cvsd_pkg::CFG_IDX_W'(k)));
      end
      if ($urandom_range(0, 4) == 0)
        write_reg(REG_NONE, cvsd_pkg::CFG_W'($urandom_range(0, 32767)));
      run_left = 0;
      run_bit  = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Encode: a wandering waveform with now and then a jump or an extreme.
        // Decode: runs of equal bits with a little single-bit noise.
        walk = walk + int'($urandom_range(0, 4095)) - 2048;
        case ($urandom_range(0, 19))
          0: walk = 32767;
          1: walk = -32768;
          2: walk = int'($urandom_range(0, 65535)) - 32768;
          default: ;
        endcase
        walk = int'(clip(walk, -32768, 32767));
        if (run_left == 0) begin
          run_bit  = 1'($urandom_range(0, 1));
          run_left = $urandom_range(1, 7);
        end
        run_left--;
        if (mode_q == cvsd_pkg::MODE_ENCODE) begin
          smp = 16'(walk);
          bin = 1'($urandom_range(0, 1));
        end else begin
          smp = 16'($urandom_range(0, 65535));
          bin = ($urandom_range(0, 9) == 0) ? ~run_bit : run_bit;
        end
        send_item(smp, bin, 1'b0, none);
      end
    end

    s_axis_tvalid <= 1'b0;
    while (cvsd_words_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== cvsd_codec_core.f =====
rtl/core/cvsd_pkg.sv
rtl/core/cvsd_mul.sv
rtl/core/cvsd_ctrl.sv
rtl/core/cvsd_codec_core.sv
test/tb_cvsd_codec_core.sv
